### hw/rtl/xpvs_pkg.sv
// Package for the crystal trim / PLL vernier search block.
// Holds widths, constants and the payload and internal struct types.
// No dependencies; used by every module in hw/rtl.
`default_nettype none

package xpvs_pkg;

   // Search range and field widths
   localparam int MAX_TRIM  = 600;
   localparam int TRIM_W    = 10;
   localparam int STEPS_W   = 16;
   localparam int RES_W     = 15;
   localparam int OFS_W     = 28;
   localparam int GAIN_W    = 18;

   // Shared divider: magnitude dividend, remainder below one PLL step
   localparam int DIV_W     = 28;
   localparam int REM_W     = 14;
   localparam int QUO_W     = 17;
   localparam int GQ_W      = 5;
   localparam int ERR_W     = 14;

   // Reciprocal of one PLL step: ceil(2^41 / 10000), exact for any 28-bit dividend
   localparam int               RECIP_SHIFT = 41;
   localparam int               DQ_W        = 2 * DIV_W - RECIP_SHIFT;
   localparam logic [DIV_W-1:0] STEP_RECIP  = 28'd219902326;

   localparam logic [TRIM_W-1:0]    TRIM_LAST = TRIM_W'(MAX_TRIM);

   // Arithmetic constants, millihertz
   localparam logic [REM_W-1:0] STEP_MHZ    = 14'd10000;
   localparam logic [REM_W-1:0] HALF_STEP   = 14'd5000;
   localparam logic [REM_W-1:0] STEP_HALF3  = 14'd15000;
   localparam logic [RES_W-1:0] NO_SOLUTION = 15'd32767;

   typedef struct packed {
      logic signed [OFS_W-1:0] offset_mhz;
      logic [GAIN_W-1:0]       trim_gain_mhz;
   } req_type;

   typedef struct packed {
      logic [TRIM_W-1:0]  trim_code;
      logic [STEPS_W-1:0] pll_steps;
      logic [RES_W-1:0]   residual_mhz;
   } rsp_type;

   // Divider result, valid when done is high
   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quot;
      logic [REM_W-1:0]  rem;
   } div_out_type;

   // Evaluated candidate for one trim code
   typedef struct packed {
      logic               ok;
      logic [ERR_W-1:0]   err;
      logic [STEPS_W-1:0] steps;
   } cand_type;

endpackage

`default_nettype wire

### hw/rtl/xtal_pll_vernier_search.sv
// Crystal trim / PLL vernier search. Each request takes the wanted offset and the
// trim sensitivity and returns one result: the first trim code with the smallest
// residual, its count of 10 Hz PLL steps and that residual (32767 if none).
// A request with zero sensitivity is answered in the cycle right after its transfer
// and busy never rises. Otherwise the shared divider runs twice, for sensitivity
// and offset, then the search walks one trim code per cycle; the trim walk sets the
// cost. The walk stops at the first exact hit or at trim code 600.
// busy drops in the strobe cycle, so the next request can transfer at the edge
// that ends it. rsp_valid pulses for one cycle and the result cannot be held, so
// the receiver must take it in that cycle.
// Depends on xpvs_pkg, xpvs_div, xpvs_cand.
`default_nettype none

module xtal_pll_vernier_search (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire xpvs_pkg::req_type req_item,
   output logic                   rsp_valid,
   output xpvs_pkg::rsp_type      rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_GAIN,
      ST_DIV_OFS,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;

   logic                                 ofs_neg_ff, ofs_neg_in;
   logic [xpvs_pkg::DIV_W-1:0]           ofs_mag_ff, ofs_mag_in;
   logic [xpvs_pkg::GQ_W-1:0]            gq_ff, gq_in;
   logic [xpvs_pkg::REM_W-1:0]           gr_ff, gr_in;
   logic signed [xpvs_pkg::QUO_W-1:0]    q_ff, q_in;
   logic [xpvs_pkg::REM_W-1:0]           r_ff, r_in;
   logic [xpvs_pkg::TRIM_W-1:0]          t_ff, t_in;
   xpvs_pkg::rsp_type                    best_ff, best_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   xpvs_pkg::rsp_type                    rsp_item_ff, rsp_item_in;

   logic                                 div_go;
   logic [xpvs_pkg::DIV_W-1:0]           div_dividend;
   xpvs_pkg::div_out_type                div_res;
   xpvs_pkg::cand_type                   cand;

   logic                                 accept;
   logic signed [xpvs_pkg::OFS_W:0]      base;
   logic [xpvs_pkg::QUO_W-1:0]           qm;
   logic                                 improve;
   xpvs_pkg::rsp_type                    fin;
   logic [xpvs_pkg::REM_W:0]             r_sum;
   logic                                 carry;

   xpvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .result   (div_res)
   );

   xpvs_cand u_cand (
      .quo  (q_ff),
      .rem  (r_ff),
      .cand (cand)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Sequencer: zero gain answers directly, else divide gain and offset, walk trims
   always_comb begin
      state_in     = state_ff;
      ofs_neg_in   = ofs_neg_ff;
      ofs_mag_in   = ofs_mag_ff;
      gq_in        = gq_ff;
      gr_in        = gr_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      div_go       = 1'b0;
      div_dividend = xpvs_pkg::DIV_W'(req_item.trim_gain_mhz);

      // Sum at trim zero: half step minus wanted offset
      base = (xpvs_pkg::OFS_W+1)'(signed'({1'b0, xpvs_pkg::HALF_STEP}))
             - {req_item.offset_mhz[xpvs_pkg::OFS_W-1], req_item.offset_mhz};
      qm   = div_res.quot[xpvs_pkg::QUO_W-1:0];

      // Best tracking for the current candidate
      improve = cand.ok && ({1'b0, cand.err} < best_ff.residual_mhz);
      fin     = best_ff;
      if (improve) begin
         fin.trim_code    = t_ff;
         fin.pll_steps    = cand.steps;
         fin.residual_mhz = {1'b0, cand.err};
      end

      // Step to the next trim code: add sensitivity as quotient and remainder
      r_sum = {1'b0, r_ff} + {1'b0, gr_ff};
      carry = r_sum >= {1'b0, xpvs_pkg::STEP_MHZ};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               best_in.trim_code    = '0;
               best_in.pll_steps    = '0;
               best_in.residual_mhz = xpvs_pkg::NO_SOLUTION;
               ofs_neg_in = base[xpvs_pkg::OFS_W];
               ofs_mag_in = base[xpvs_pkg::OFS_W] ? xpvs_pkg::DIV_W'(-base)
                                                  : xpvs_pkg::DIV_W'(base);
               if (req_item.trim_gain_mhz == '0) begin
                  rsp_valid_in             = 1'b1;
                  rsp_item_in.trim_code    = '0;
                  rsp_item_in.pll_steps    = '0;
                  rsp_item_in.residual_mhz = xpvs_pkg::NO_SOLUTION;
               end else begin
                  div_go   = 1'b1;
                  state_in = ST_DIV_GAIN;
               end
            end
         end
         ST_DIV_GAIN: begin
            if (div_res.done) begin
               gq_in        = div_res.quot[xpvs_pkg::GQ_W-1:0];
               gr_in        = div_res.rem;
               div_go       = 1'b1;
               div_dividend = ofs_mag_ff;
               state_in     = ST_DIV_OFS;
            end
         end
         ST_DIV_OFS: begin
            if (div_res.done) begin
               // Turn the magnitude division into a floor quotient and remainder
               if (!ofs_neg_ff) begin
                  q_in = qm;
                  r_in = div_res.rem;
               end else if (div_res.rem != '0) begin
                  q_in = ~qm;
                  r_in = xpvs_pkg::STEP_MHZ - div_res.rem;
               end else begin
                  q_in = -qm;
                  r_in = '0;
               end
               t_in     = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            best_in = fin;
            if ((cand.ok && cand.err == '0) || t_ff == xpvs_pkg::TRIM_LAST) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = fin;
               state_in     = ST_IDLE;
            end else begin
               t_in = t_ff + 1'b1;
               r_in = carry ? xpvs_pkg::REM_W'(r_sum - {1'b0, xpvs_pkg::STEP_MHZ})
                            : r_sum[xpvs_pkg::REM_W-1:0];
               q_in = q_ff + xpvs_pkg::QUO_W'(gq_ff) + xpvs_pkg::QUO_W'(carry);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ofs_neg_ff  <= ofs_neg_in;
      ofs_mag_ff  <= ofs_mag_in;
      gq_ff       <= gq_in;
      gr_ff       <= gr_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      best_ff     <= best_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### hw/rtl/xpvs_div.sv
// Shared divider by one PLL step (10000): reciprocal multiply, then remainder.
// done pulses with the registered remainder. Depends on xpvs_pkg.
`default_nettype none

module xpvs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [xpvs_pkg::DIV_W-1:0]    dividend,
   output xpvs_pkg::div_out_type              result
);

   logic [xpvs_pkg::DIV_W-1:0]     num_ff, num_in;
   logic [xpvs_pkg::DQ_W-1:0]      quo_ff, quo_in;
   logic [xpvs_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic                           mul_ff, mul_in;
   logic                           fix_ff, fix_in;
   logic                           done_ff, done_in;
   logic [2*xpvs_pkg::DIV_W-1:0]   prod;
   logic [xpvs_pkg::DIV_W-1:0]     back;

   // Load, then quotient from the reciprocal product, then remainder
   always_comb begin
      prod    = (2*xpvs_pkg::DIV_W)'(num_ff) * (2*xpvs_pkg::DIV_W)'(xpvs_pkg::STEP_RECIP);
      back    = xpvs_pkg::DIV_W'(quo_ff) * xpvs_pkg::DIV_W'(xpvs_pkg::STEP_MHZ);
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      mul_in  = 1'b0;
      fix_in  = 1'b0;
      done_in = 1'b0;
      if (go) begin
         num_in = dividend;
         mul_in = 1'b1;
      end else if (mul_ff) begin
         quo_in = prod[2*xpvs_pkg::DIV_W-1:xpvs_pkg::RECIP_SHIFT];
         fix_in = 1'b1;
      end else if (fix_ff) begin
         // remainder is below one step, so its low bits are enough
         rem_in  = xpvs_pkg::REM_W'(num_ff - back);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign result.done = done_ff;
   assign result.quot = xpvs_pkg::DIV_W'(quo_ff);
   assign result.rem  = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/xpvs_cand.sv
// Candidate evaluation: from the floor quotient and remainder of
// (trim effect - offset + half step) / step, forms steps, error and validity.
// Depends on xpvs_pkg.
`default_nettype none

module xpvs_cand (
   input  wire logic signed [xpvs_pkg::QUO_W-1:0] quo,
   input  wire logic [xpvs_pkg::REM_W-1:0]        rem,
   output xpvs_pkg::cand_type                     cand
);

   logic q_neg;
   logic q_minus_one;

   always_comb begin
      q_neg       = quo[xpvs_pkg::QUO_W-1];
      q_minus_one = &quo;
      cand.ok     = 1'b0;
      cand.err    = '0;
      cand.steps  = '0;
      if (!q_neg) begin
         // Count is the quotient; error is distance of remainder from half step
         cand.ok    = 1'b1;
         cand.steps = quo[xpvs_pkg::STEPS_W-1:0];
         cand.err   = (rem >= xpvs_pkg::HALF_STEP) ? rem - xpvs_pkg::HALF_STEP
                                                   : xpvs_pkg::HALF_STEP - rem;
      end else if (q_minus_one && rem != '0) begin
         // Small negative sum truncates to a zero count
         cand.ok  = 1'b1;
         cand.err = xpvs_pkg::STEP_HALF3 - rem;
      end
   end

endmodule

`default_nettype wire

### dv/xpvs_search_checker.sv
// Checker for the crystal trim / PLL vernier search block.
// Predicts each result from the accepted request and compares it on the strobe.
// Depends on xpvs_pkg; instantiated beside the block by tb_xtal_pll_vernier_search.
module xpvs_search_checker
   import xpvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_item,
   input  logic        rsp_valid,
   input  rsp_type     rsp_item,
   output int unsigned mismatch_total,
   output int unsigned results_owed
);

   localparam longint PLL_STEP  = longint'(STEP_MHZ);
   localparam longint HALF_STEP = PLL_STEP / 2;
   localparam longint NO_FIT    = longint'(NO_SOLUTION);

   // Best fits predicted for accepted requests, oldest first
   rsp_type     best_fit_q[$];
   int unsigned mismatch_count = 0;

   assign mismatch_total = mismatch_count;

   // Walk every trim code; keep the first strictly smallest residual, stop on an exact hit
   function automatic rsp_type predict_best_trim(input req_type item);
      longint  want, gain, effect, steps, err, best_err, best_steps;
      int      best_trim;
      rsp_type fit;
      want = {{(64-OFS_W){item.offset_mhz[OFS_W-1]}}, item.offset_mhz};
      gain = longint'(item.trim_gain_mhz);
      best_trim  = 0;
      best_steps = 0;
      best_err   = NO_FIT;
      if (gain != 0) begin
         for (int t = 0; t <= MAX_TRIM && best_err != 0; t++) begin
            effect = longint'(t) * gain;
            // signed division truncates toward zero, so small negatives land on 0
            steps = (effect - want + HALF_STEP) / PLL_STEP;
            if (steps >= 0) begin
               err = effect - steps * PLL_STEP - want;
               if (err < 0)
                  err = -err;
               if (err < best_err) begin
                  best_trim  = t;
                  best_steps = steps;
                  best_err   = err;
               end
            end
         end
      end
      fit.trim_code    = best_trim[TRIM_W-1:0];
      fit.pll_steps    = best_steps[STEPS_W-1:0];
      fit.residual_mhz = best_err[RES_W-1:0];
      return fit;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: vernier search mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Result side first, then the request side, on every edge
   always @(posedge clock) begin : watch_transfers
      rsp_type want_fit;
      if (reset) begin
         best_fit_q.delete();
         results_owed <= 0;
      end else begin
         if (rsp_valid) begin
            if (best_fit_q.size() == 0) begin
               report_mismatch($sformatf("result trim %0d steps %0d residual %0d with none due",
                  rsp_item.trim_code, rsp_item.pll_steps, rsp_item.residual_mhz));
            end else begin
               want_fit = best_fit_q.pop_front();
               if (rsp_item.trim_code !== want_fit.trim_code)
                  report_mismatch($sformatf("trim_code got %0d expected %0d",
                     rsp_item.trim_code, want_fit.trim_code));
               if (rsp_item.pll_steps !== want_fit.pll_steps)
                  report_mismatch($sformatf("pll_steps got %0d expected %0d",
                     rsp_item.pll_steps, want_fit.pll_steps));
               if (rsp_item.residual_mhz !== want_fit.residual_mhz)
                  report_mismatch($sformatf("residual_mhz got %0d expected %0d",
                     rsp_item.residual_mhz, want_fit.residual_mhz));
            end
         end
         if (start && !busy)
            best_fit_q.push_back(predict_best_trim(req_item));
         results_owed <= best_fit_q.size();
      end
   end

endmodule

### dv/tb_xtal_pll_vernier_search.sv
// Testbench top for xtal_pll_vernier_search: clock, reset, request stimulus and verdict.
// Directed corner requests, then random bursts; checking is done by xpvs_search_checker.
// Depends on xpvs_pkg, xpvs_search_checker and the block under test.
module tb_xtal_pll_vernier_search;
   import xpvs_pkg::*;

   localparam int     RANDOM_ITEMS  = 980;
   localparam int     IDLE_LIMIT    = 4000;
   localparam int     SETTLE_CYCLES = 700;
   localparam int     N_DIRECTED    = 23;
   localparam longint OFS_MAX       = 134217727;
   localparam longint OFS_MIN       = -134217728;
   localparam longint GAIN_MAX      = 262143;
   localparam longint PLL_STEP      = longint'(STEP_MHZ);

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_item  = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_item;
   int unsigned mismatch_total;
   int unsigned results_owed;
   int unsigned idle_cycles = 0;
   int          sent;
   int          burst;

   // Corner requests: offset, gain
   longint directed_cases [N_DIRECTED][2] = '{
      '{0, 1},                    // exact hit on the first trim
      '{12345, 0},                // unusable gain
      '{OFS_MIN, 0},
      '{OFS_MAX, GAIN_MAX},
      '{OFS_MIN, GAIN_MAX},
      '{OFS_MAX, 1},              // every step count negative: no solution
      '{OFS_MIN, 1},
      '{-1, GAIN_MAX},
      '{3, 10000},                // every trim ties, lowest wins
      '{600, 1},                  // exact hit only on the last trim
      '{2100, 7},                 // exact hit mid-range
      '{14999, 1},                // truncation toward zero keeps step count 0
      '{15000, 1},                // step count -1 only at trim zero, then large residuals
      '{5000, 1},
      '{-5000, 1},
      '{-5000, 10000},            // half-step tie
      '{100000, GAIN_MAX},
      '{0, GAIN_MAX},
      '{-7, 3},
      '{1, 131072},
      '{-67108864, 87381},
      '{134210000, 223683},
      '{9999, 0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   xtal_pll_vernier_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   xpvs_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .mismatch_total (mismatch_total),
      .results_owed   (results_owed)
   );

   // Watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("xtal_pll_vernier_search regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(input longint ofs, input longint gain);
      req_type item;
      item.offset_mhz    = ofs[OFS_W-1:0];
      item.trim_gain_mhz = gain[GAIN_W-1:0];
      return item;
   endfunction

   // Half exact or near-exact targets, the rest small-range and raw random requests
   function automatic req_type gen_search_req();
      longint      ofs, gain, effect, steps, steps_lo;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         gain = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 2000)
                                            : $urandom_range(1, GAIN_MAX);
         effect = longint'($urandom_range(0, MAX_TRIM)) * gain;
         steps_lo = (effect > OFS_MAX) ? (effect - OFS_MAX + PLL_STEP - 1) / PLL_STEP : 0;
         if ($urandom_range(0, 1) == 1)
            steps = steps_lo + longint'($urandom_range(0, 13000));
         else
            steps = steps_lo + longint'($urandom_range(0, 20));
         ofs = effect - steps * PLL_STEP;
         // near miss
         if ($urandom_range(0, 3) == 0)
            ofs = ofs + longint'($urandom_range(0, 100)) - 50;
         if (ofs > OFS_MAX)
            ofs = OFS_MAX;
      end else if (kind < 8) begin
         ofs  = longint'($urandom_range(0, 40000)) - 20000;
         gain = longint'($urandom_range(0, 100));
      end else begin
         ofs  = longint'($urandom);
         gain = ($urandom_range(0, 19) == 0) ? 0 : longint'($urandom);
      end
      return make_req(ofs, gain);
   endfunction

   // start is left high so a following request goes out without a gap
   task automatic send_item(input req_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners back to back
      foreach (directed_cases[i])
         send_item(make_req(directed_cases[i][0], directed_cases[i][1]));
      drain_results();

      // Random bursts with random gaps, an occasional full drain
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_item(gen_search_req());
            sent++;
         end
         if ($urandom_range(0, 15) == 0)
            drain_results();
         else if ($urandom_range(0, 3) == 0)
            pause_sender($urandom_range(0, 700));
         else
            pause_sender($urandom_range(0, 8));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("xtal_pll_vernier_search regression: pass");
      else
         $display("xtal_pll_vernier_search regression: fail");
      $finish;
   end

endmodule
